### design/bfac_pkg.sv
// Package: constants, types and hash helpers for the Bloom filter unit.
`default_nettype none
package bfac_pkg;
  localparam int unsigned FilterBits = 65536;
  localparam int unsigned NumProbes = 3;
  localparam int unsigned WordBits = 64;
  localparam int unsigned StoreWords = FilterBits / WordBits;
  localparam int unsigned AddrW = $clog2(StoreWords);
  localparam int unsigned BitW = $clog2(WordBits);
  localparam int unsigned IdxW = $clog2(FilterBits);
  localparam int unsigned SizeW = 17;
  localparam int unsigned ProbeW = $clog2(NumProbes + 1);
  localparam int unsigned HashSteps = 6;
  localparam logic [31:0] KnuthMul = 32'd2654435761;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(65536);
  localparam logic [0:0] FuncAdd = 1'b0;
  localparam logic [0:0] FuncCheck = 1'b1;
  localparam int unsigned PaddrW = 3;
  localparam logic [PaddrW-1:0] RegFilterSize = 3'd0;

  typedef struct packed {
    logic        func;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] key_total;
  } rsp_t;

  // one of the six mixing steps of the Jenkins integer hash
  function automatic logic [63:0] jenkins_step(input logic [63:0] x, input logic [2:0] step);
    logic [63:0] y;
    case (step)
      3'd0: y = (x + 64'h7ed55d16) + (x << 12);
      3'd1: y = (x ^ 64'hc761c23c) ^ (x >> 19);
      3'd2: y = (x + 64'h165667b1) + (x << 5);
      3'd3: y = (x + 64'hd3a2646c) ^ (x << 9);
      3'd4: y = (x + 64'hfd7046c5) + (x << 3);
      3'd5: y = (x ^ 64'hb55a4f09) ^ (x >> 16);
      default: y = x;
    endcase
    return y;
  endfunction
endpackage
`default_nettype wire

### design/bfac_if.sv
// Interfaces: valid/ready channels carrying one request word (req_t) or one result word (rsp_t).
`default_nettype none
interface bfac_req_if;
  logic valid;
  logic ready;
  bfac_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bfac_rsp_if;
  logic valid;
  logic ready;
  bfac_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### design/bfac_modu.sv
// Iterative reducer: 64-bit value modulo a 17-bit size, one bit per cycle.
`default_nettype none
module bfac_modu (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [63:0]               val_i,
  input  wire logic [bfac_pkg::SizeW-1:0] size_i,
  output logic                           done_o,
  output logic [bfac_pkg::SizeW-1:0]     rem_o
);
  import bfac_pkg::*;
  logic [63:0] val_q, val_d;
  logic [SizeW:0] rem_q, rem_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [SizeW+1:0] trial;

  always_comb begin
    val_d = val_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q, val_q[63]};
    if (start_i) begin
      val_d = val_i;
      rem_d = '0;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, 1'b0, size_i}) begin
        rem_d = (SizeW+1)'(trial - {2'b0, size_i});
      end else begin
        rem_d = trial[SizeW:0];
      end
      val_d = {val_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign rem_o = rem_d[SizeW-1:0];
endmodule
`default_nettype wire

### design/bloom_filter_add_check_unit.sv
// Top level: Bloom filter add/check unit with a word-wide bit store memory.
//
// Each accepted word is an add or a check of a 64-bit key. The unit handles one
// key at a time: after reset it first clears the 1024-word bit store, one word
// a cycle (input not ready). Per key it accepts the word, then runs six hash
// steps (one Jenkins mixing step each; the Knuth product is built from two
// 32x32 multiplies in the first two). For each of the three probes a
// bit-serial reducer takes the probe sum modulo filter_size, then the store
// word is read and written back for an add. The serial modulo dominates the
// time per key. A check skips remaining probes at the first clear bit. The
// result register frees once taken; the next key is accepted only after the
// result has been taken.
`default_nettype none
module bloom_filter_add_check_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  bfac_req_if.sink                        req,
  bfac_rsp_if.source                      rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bfac_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bfac_pkg::*;

  typedef enum logic [6:0] {
    StClr  = 7'b0000001,
    StIdle = 7'b0000010,
    StHash = 7'b0000100,
    StMod  = 7'b0001000,
    StRd   = 7'b0010000,
    StWr   = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] act_size;
  logic [63:0] mem [StoreWords];
  logic [63:0] rdata_q;
  logic [AddrW-1:0] clr_q;
  logic func_q;
  logic [63:0] key_q, h2_q, sum_q;
  logic [2:0] hstep_q;
  logic [31:0] kmul_a;
  logic [63:0] kmul_prod;
  logic [ProbeW-1:0] probe_q;
  logic [IdxW-1:0] idx_q;
  logic found_q;
  logic [31:0] count_q;
  logic mod_start, mod_done;
  logic [SizeW-1:0] mod_rem;
  logic mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [63:0] mem_wdata;
  logic bit_set;

  // register port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == RegFilterSize) prdata = 32'(size_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeReset;
    else if (psel && penable && pwrite && paddr == RegFilterSize)
      size_q <= pwdata[SizeW-1:0];
  end

  // size zero acts as one, size above the store acts as full
  always_comb begin
    act_size = size_q;
    if (size_q == '0) act_size = SizeW'(1);
    else if (size_q > SizeW'(FilterBits)) act_size = SizeW'(FilterBits);
  end

  bfac_modu u_modu (
    .clk_i, .rst_ni,
    .start_i(mod_start), .val_i(sum_q), .size_i(act_size),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  // Knuth product, 64 bits wrapped: low half of key in step 0, high half in step 1
  assign kmul_a = (hstep_q == 3'd0) ? key_q[31:0] : key_q[63:32];
  assign kmul_prod = kmul_a * KnuthMul;

  assign bit_set = rdata_q[idx_q[BitW-1:0]];
  assign req.ready = (state_q == StIdle);
  assign rsp.valid = (state_q == StOut);
  assign rsp.data.found = found_q;
  assign rsp.data.key_total = count_q;

  always_comb begin
    state_d = state_q;
    mod_start = 1'b0;
    mem_we = 1'b0;
    mem_addr = idx_q[IdxW-1:BitW];
    mem_wdata = rdata_q | (64'd1 << idx_q[BitW-1:0]);
    unique case (state_q)
      StClr: begin
        mem_we = 1'b1;
        mem_addr = clr_q;
        mem_wdata = '0;
        if (clr_q == AddrW'(StoreWords - 1)) state_d = StIdle;
      end
      StIdle: if (req.valid) state_d = StHash;
      StHash: begin
        if (hstep_q == 3'(HashSteps - 1)) begin
          state_d = StMod;
          mod_start = 1'b1;
        end
      end
      StMod: if (mod_done) state_d = StRd;
      StRd: state_d = StWr;
      StWr: begin
        if (func_q == FuncAdd) mem_we = 1'b1;
        if (probe_q == ProbeW'(NumProbes - 1)) state_d = StOut;
        else if (func_q == FuncCheck && !bit_set) state_d = StOut;
        else begin
          state_d = StMod;
          mod_start = 1'b1;
        end
      end
      StOut: if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      clr_q <= '0;
      count_q <= '0;
      probe_q <= '0;
      found_q <= 1'b0;
      hstep_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClr) clr_q <= clr_q + AddrW'(1);
      if (state_q == StIdle && req.valid) begin
        probe_q <= '0;
        hstep_q <= '0;
        found_q <= (req.data.func == FuncCheck);
      end
      if (state_q == StHash) hstep_q <= hstep_q + 3'd1;
      if (state_q == StWr) begin
        probe_q <= probe_q + ProbeW'(1);
        if (func_q == FuncCheck && !bit_set) found_q <= 1'b0;
        if (func_q == FuncAdd && probe_q == ProbeW'(NumProbes - 1)
            && count_q != 32'hFFFF_FFFF)
          count_q <= count_q + 32'd1;
      end
    end
  end

  // sum_q holds h1 when the first modulo starts and moves on by h2 in each
  // read cycle, so it is h1 + j*h2 when probe j starts
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req.valid) begin
      func_q <= req.data.func;
      key_q <= req.data.key;
      h2_q <= req.data.key;
    end
    if (state_q == StHash) begin
      h2_q <= jenkins_step(h2_q, hstep_q);
      if (hstep_q == 3'd0) sum_q <= kmul_prod;
      else if (hstep_q == 3'd1) sum_q <= sum_q + {kmul_prod[31:0], 32'd0};
    end
    if (mod_done) idx_q <= IdxW'(mod_rem);
    if (state_q == StRd) sum_q <= sum_q + h2_q;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClr) |-> !req.ready) else $error("accept during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && func_q == FuncAdd) |-> !found_q) else $error("add reported found");
endmodule
`default_nettype wire

### test/bloom_result_checker.sv
// Checker: watches the key and result channels, predicts each result and compares.
`timescale 1ns / 1ps
module bloom_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bfac_req_if                         req,
  bfac_rsp_if                         rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [bfac_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          outstanding
);
  import bfac_pkg::*;

  logic [63:0]      filt_words [StoreWords];
  logic [31:0]      keys_added;
  logic [SizeW-1:0] size_reg;
  rsp_t             expected_results [$];

  function automatic logic [63:0] mix_key(input logic [63:0] k);
    logic [63:0] v;
    v = k;
    v = (v + 64'h7ed55d16) + (v << 12);
    v = (v ^ 64'hc761c23c) ^ (v >> 19);
    v = (v + 64'h165667b1) + (v << 5);
    v = (v + 64'hd3a2646c) ^ (v << 9);
    v = (v + 64'hfd7046c5) + (v << 3);
    v = (v ^ 64'hb55a4f09) ^ (v >> 16);
    return v;
  endfunction

  // Updates the filter image and returns the result the unit must give.
  function automatic rsp_t predict_bloom_result(input req_t w);
    rsp_t        r;
    logic [63:0] h1, h2, span, idx;
    span = (size_reg == '0) ? 64'd1 :
           (size_reg > SizeW'(FilterBits)) ? 64'(FilterBits) : 64'(size_reg);
    h1 = w.key * KnuthMul;
    h2 = mix_key(w.key);
    r.found = (w.func == FuncCheck);
    for (int j = 0; j < NumProbes; j++) begin
      idx = (h1 + 64'(j) * h2) % span;
      if (w.func == FuncAdd) begin
        filt_words[idx[IdxW-1:BitW]][idx[BitW-1:0]] = 1'b1;
      end else if (r.found && !filt_words[idx[IdxW-1:BitW]][idx[BitW-1:0]]) begin
        r.found = 1'b0;
      end
    end
    if (w.func == FuncAdd && keys_added != 32'hffff_ffff) keys_added++;
    r.key_total = keys_added;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got, want;
    if (!rst_ni) begin
      foreach (filt_words[i]) filt_words[i] = '0;
      keys_added = '0;
      size_reg = SizeReset;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegFilterSize)
        size_reg = pwdata[SizeW-1:0];
      if (req.valid && req.ready)
        expected_results.push_back(predict_bloom_result(req.data));
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
          if (got.key_total !== want.key_total)
            report_mismatch($sformatf("key_total %0d, expected %0d",
                                      got.key_total, want.key_total));
        end
      end
    end
    outstanding = expected_results.size();
  end
endmodule

### test/tb_bloom_filter_add_check_unit.sv
// Testbench top: drives keys and filter sizes into the Bloom filter unit, gives the verdict.
`timescale 1ns / 1ps
module tb_bloom_filter_add_check_unit;
  import bfac_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                outstanding;

  // Random idling on both sides; turned off for the closing stretch.
  bit                gaps_on;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit                hold_request;
  logic [63:0]       added_keys [$];

  bfac_req_if req ();
  bfac_rsp_if rsp ();

  bloom_filter_add_check_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bloom_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .rsp         (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Run limit: ~2000 keys plus idling, stalls and the clear after reset come to
  // about 5 ms; allow far more.
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // result register stays full and the unit refuses new keys.
  initial begin
    int hold;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0 && hold_request) begin
        hold = 900;
        hold_request = 1'b0;
      end else if (hold == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 6);
      end
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Register write: setup phase, then access phase with penable, then back to idle.
  task automatic write_reg(input logic [PaddrW-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one word and returns at the edge that accepts it. ready is
  // looked at on the falling edge so the check is free of edge races.
  task automatic send_key(input logic func, input logic [63:0] key);
    req_t w;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    w.func = func;
    w.key  = key;
    req.valid <= 1'b1;
    req.data  <= w;
    forever begin
      @(negedge clk_i);
      if (req.ready) break;
    end
    @(posedge clk_i);
    if (func == FuncAdd && added_keys.size() < 400) added_keys.push_back(key);
  endtask

  // Mostly random keys; a share re-sends keys already added, as add or check, so
  // that hits are common, plus a few sparse and dense bit patterns.
  task automatic send_random_keys(input int count);
    logic [63:0] k;
    logic        f;
    int          pick;
    for (int n = 0; n < count; n++) begin
      f    = $urandom_range(0, 1);
      pick = $urandom_range(0, 9);
      if (pick < 3 && added_keys.size() > 0)
        k = added_keys[$urandom_range(0, added_keys.size() - 1)];
      else if (pick == 3)
        k = 64'd1 << $urandom_range(0, 63);
      else if (pick == 4)
        k = ~(64'd1 << $urandom_range(0, 63));
      else
        k = {$urandom, $urandom};
      send_key(f, k);
    end
  endtask

  // Quiet point: every result back, then a margin before any register write.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] sizes [8];
    sizes = '{32'd1, 32'd0, 32'h1ffff, 32'd64, 32'd100, 32'd65535, 32'd7, 32'd65536};
    rst_ni    = 1'b0;
    gaps_on   = 1'b1;
    hold_request = 1'b0;
    req.valid <= 1'b0;
    req.data  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(RegFilterSize, 32'd65536);
    // Unmapped register: the write must leave the size alone.
    write_reg(PaddrW'(4), 32'd3);

    // Directed: extreme keys, add then check, checks of absent keys.
    send_key(FuncCheck, 64'd0);
    send_key(FuncAdd,   64'd0);
    send_key(FuncCheck, 64'd0);
    send_key(FuncCheck, '1);
    send_key(FuncAdd,   '1);
    send_key(FuncCheck, '1);
    send_key(FuncAdd,   64'h8000_0000_0000_0000);
    send_key(FuncCheck, 64'h8000_0000_0000_0000);
    send_key(FuncCheck, 64'h0000_0000_0000_0001);
    send_key(FuncAdd,   64'haaaa_aaaa_aaaa_aaaa);
    send_key(FuncAdd,   64'h5555_5555_5555_5555);
    send_key(FuncCheck, 64'haaaa_aaaa_aaaa_aaaa);
    send_key(FuncCheck, 64'h5555_5555_5555_5555);
    send_key(FuncCheck, 64'h0123_4567_89ab_cdef);
    // Long receiver hold-off while keys keep coming.
    hold_request = 1'b1;
    send_random_keys(6);
    drain();

    // Several sizes, the extremes among them: zero acts as one and the
    // 17-bit maximum is clamped to the store size.
    foreach (sizes[i]) begin
      write_reg(RegFilterSize, sizes[i]);
      if (i == 7) begin
        send_random_keys(200);
        gaps_on = 1'b0;
        send_random_keys(200);
      end else begin
        send_random_keys(220);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
design/bfac_pkg.sv
design/bfac_if.sv
design/bfac_modu.sv
design/bloom_filter_add_check_unit.sv
test/bloom_result_checker.sv
test/tb_bloom_filter_add_check_unit.sv
